// ===== hdl/dqm_pkg.sv =====
// ----------------------------------------------------------------------------
// dqm_pkg
// Shared types and codes for the deque with middle insert and remove.
// ----------------------------------------------------------------------------
package dqm_pkg;

  localparam int ModeBits   = 3;
  localparam int WordBits   = 32;
  localparam int StatusBits = 2;
  localparam int CountBits  = 6;

  typedef logic [ModeBits-1:0]   mode_t;
  typedef logic [WordBits-1:0]   word_t;
  typedef logic [StatusBits-1:0] status_t;
  typedef logic [CountBits-1:0]  count_t;

  // Operation codes
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_INS_MID    = 3'd2;
  localparam mode_t MODE_POP_FRONT  = 3'd3;
  localparam mode_t MODE_POP_BACK   = 3'd4;
  localparam mode_t MODE_REM_MID    = 3'd5;

  // Status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_SHORT = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  // Broadcast shift command from the controller to every cell
  typedef struct packed {
    logic ins;   // open a gap at pos and store the new word there
    logic rem;   // close the gap at pos
  } cell_ctl_t;

endpackage

// ===== hdl/dqm_if.sv =====
// ----------------------------------------------------------------------------
// dqm_req_if / dqm_rsp_if
// Valid/ready channels for operations and their results.
// ----------------------------------------------------------------------------
interface dqm_req_if
  import dqm_pkg::*;
();
  logic  valid;
  logic  ready;
  mode_t mode;
  word_t entry;

  modport source (output valid, output mode, output entry, input ready);
  modport sink   (input valid, input mode, input entry, output ready);
endinterface

interface dqm_rsp_if
  import dqm_pkg::*;
();
  logic    valid;
  logic    ready;
  word_t   removed_entry;
  status_t status;
  count_t  count_after;

  modport source (output valid, output removed_entry, output status,
                  output count_after, input ready);
  modport sink   (input valid, input removed_entry, input status,
                  input count_after, output ready);
endinterface

// ===== hdl/dqm_cell.sv =====
// ----------------------------------------------------------------------------
// dqm_cell
// One list position: holds a word and trades it with its neighbors.
// ----------------------------------------------------------------------------
module dqm_cell
  import dqm_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int POS_BITS   = 6,
  parameter int ENTRY_BITS = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [POS_BITS-1:0]   pos,
  input  logic [ENTRY_BITS-1:0] new_word,
  input  logic [ENTRY_BITS-1:0] left_word,
  input  logic [ENTRY_BITS-1:0] right_word,
  output logic [ENTRY_BITS-1:0] word,
  output logic [ENTRY_BITS-1:0] tap
);

  localparam logic [POS_BITS-1:0] MyIdx = POS_BITS'(INDEX);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (MyIdx == pos);
  assign past_pos = (MyIdx > pos);

  // Present the held word when this cell sits at pos; on a remove it is the removed word
  assign tap = at_pos ? word : '0;

  // Shift toward the back on insert, toward the front on remove
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_pos) begin
        word <= new_word;
      end else if (past_pos) begin
        word <= left_word;
      end
    end else if (ctl.rem) begin
      if (at_pos || past_pos) begin
        word <= right_word;
      end
    end
  end

endmodule

// ===== hdl/deque_with_middle_insert_remove.sv =====
// The result of an operation is registered and presented in the cycle after its transfer.
// Throughput: one operation per cycle while the receiver takes every result; all
//   cells shift in the same cycle, and a result left waiting holds off the input.
// Reset: clears the fill count and the result valid; cell contents are left
//   as they are and are only read below the fill count.
// ----------------------------------------------------------------------------
// deque_with_middle_insert_remove
// Bounded ordered list with push/pop at both ends and at the middle,
// built as a row of shifting cells.
// ----------------------------------------------------------------------------
module deque_with_middle_insert_remove
  import dqm_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int ENTRY_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  dqm_req_if.sink   req,
  dqm_rsp_if.source rsp
);

  localparam int PosBits = $clog2(DEPTH + 1);
  localparam logic [PosBits-1:0] Full = PosBits'(DEPTH);

  logic [PosBits-1:0]    count;
  logic [PosBits-1:0]    count_next;
  logic [PosBits-1:0]    pos;
  logic                  xfer;
  logic                  do_ins;
  logic                  do_rem;
  status_t               status_next;
  cell_ctl_t             ctl;
  logic [ENTRY_BITS-1:0] new_word;
  logic [ENTRY_BITS-1:0] words [DEPTH];
  logic [ENTRY_BITS-1:0] taps  [DEPTH];
  logic [ENTRY_BITS-1:0] picked;

  assign req.ready = !rsp.valid || rsp.ready;
  assign xfer      = req.valid && req.ready;
  assign new_word  = ENTRY_BITS'(req.entry);

  // Decode the operation: target position, action and status
  always_comb begin
    pos         = '0;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    status_next = ST_OK;
    case (req.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        pos = (req.mode == MODE_PUSH_FRONT) ? '0 : count;
        if (count == Full) begin
          status_next = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      MODE_INS_MID: begin
        pos = PosBits'((count + PosBits'(1)) >> 1);
        if (count < PosBits'(2)) begin
          status_next = ST_SHORT;
        end else if (count == Full) begin
          status_next = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        pos = (req.mode == MODE_POP_FRONT) ? '0 : count - PosBits'(1);
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          do_rem = 1'b1;
        end
      end
      MODE_REM_MID: begin
        pos = count >> 1;
        if (count < PosBits'(2)) begin
          status_next = ST_SHORT;
        end else begin
          do_rem = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.ins = xfer && do_ins;
  assign ctl.rem = xfer && do_rem;

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + PosBits'(1);
    end else if (ctl.rem) begin
      count_next = count - PosBits'(1);
    end
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_BITS-1:0] left_w;
    logic [ENTRY_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    dqm_cell #(
      .INDEX      (i),
      .POS_BITS   (PosBits),
      .ENTRY_BITS (ENTRY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

  // Merge the one-hot cell taps into the removed word
  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | taps[i];
    end
  end

  // Hold the fill count and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (xfer) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      rsp.removed_entry <= ctl.rem ? WordBits'(picked) : '0;
      rsp.status        <= status_next;
      rsp.count_after   <= CountBits'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("fill count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !xfer |=> (count == $past(count)))
    else $error("fill count moved without a transfer");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    xfer && status_next == ST_FULL |=> rsp.valid && rsp.count_after == CountBits'(DEPTH))
    else $error("full status with a count below depth");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.removed_entry == '0)
    else $error("refused operation returned a word");
`endif

endmodule

// ===== test/dqm_scoreboard.sv =====
// ----------------------------------------------------------------------------
// dqm_scoreboard
// Watches the operation and result channels of the deque, keeps its own
// ordered list of entries, predicts each result and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module dqm_scoreboard
  import dqm_pkg::*;
#(
  parameter int Depth     = 32,
  parameter int EntryBits = 32
) (
  input  logic      clk,
  input  logic      rst,
  dqm_req_if        req,
  dqm_rsp_if        rsp,
  output int        mismatches,
  output int        pending,
  output int        compared,
  output int        refused,
  output int        peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam word_t EntryMask = word_t'((64'd1 << EntryBits) - 64'd1);

  typedef struct packed {
    word_t   removed;
    status_t status;
    count_t  count;
  } outcome_t;

  word_t    held[$];      // predicted list, position 0 at the front
  outcome_t awaited[$];   // predicted results, oldest first
  int       errs     = 0;
  int       seen     = 0;
  int       rejected = 0;
  int       deepest  = 0;

  // Apply one operation to the predicted list and return its result.
  function automatic outcome_t apply_operation(mode_t op, word_t word);
    outcome_t res;
    int unsigned n;
    int unsigned pos;
    n = held.size();
    res = '0;
    res.status = ST_OK;
    word = word & EntryMask;
    case (op)
      MODE_PUSH_FRONT: begin
        if (n >= Depth) res.status = ST_FULL;
        else held.push_front(word);
      end
      MODE_PUSH_BACK: begin
        if (n >= Depth) res.status = ST_FULL;
        else held.push_back(word);
      end
      MODE_INS_MID: begin
        // short check comes before the full check
        if (n < 2) res.status = ST_SHORT;
        else if (n >= Depth) res.status = ST_FULL;
        else held.insert((n - 1) / 2 + 1, word);
      end
      MODE_POP_FRONT: begin
        if (n == 0) res.status = ST_EMPTY;
        else res.removed = held.pop_front();
      end
      MODE_POP_BACK: begin
        if (n == 0) res.status = ST_EMPTY;
        else res.removed = held.pop_back();
      end
      MODE_REM_MID: begin
        if (n < 2) res.status = ST_SHORT;
        else begin
          pos = n / 2;
          res.removed = held[pos];
          held.delete(pos);
        end
      end
      default: ;  // spare codes leave the list alone
    endcase
    res.count = count_t'(held.size());
    return res;
  endfunction

  // Count a wrong field and show the first few.
  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    errs++;
    if (errs <= 10)
      $display("%0t: %s wrong: expected %0h, got %0h", $realtime, field, want, got);
  endtask

  // Compare results first, then record the prediction for a new operation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        seen++;
        if (awaited.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result with nothing outstanding: removed %0h status %0d count %0d",
                     $realtime, rsp.removed_entry, rsp.status, rsp.count_after);
        end else begin
          want = awaited.pop_front();
          if (rsp.removed_entry !== want.removed)
            flag_field("removed_entry", want.removed, rsp.removed_entry);
          if (rsp.status !== want.status)
            flag_field("status", want.status, rsp.status);
          if (rsp.count_after !== want.count)
            flag_field("count_after", want.count, rsp.count_after);
        end
      end
      if (req.valid && req.ready) begin
        want = apply_operation(req.mode, req.entry);
        if (want.status != ST_OK) rejected++;
        if (held.size() > deepest) deepest = held.size();
        awaited.push_back(want);
      end
    end
    mismatches <= errs;
    pending    <= awaited.size();
    compared   <= seen;
    refused    <= rejected;
    peak_fill  <= deepest;
  end

endmodule

// ===== test/deque_with_middle_insert_remove_tb.sv =====
// ----------------------------------------------------------------------------
// deque_with_middle_insert_remove_tb
// Drives directed and random list operations into the deque with bursty
// traffic and a stalling receiver; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module deque_with_middle_insert_remove_tb;
  import dqm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    Depth        = 32;
  localparam int    EntryBits    = 32;
  localparam int    RandomTarget = 1350;
  localparam mode_t MODE_SPARE_A = 3'd6;
  localparam mode_t MODE_SPARE_B = 3'd7;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_LIGHT,
    DRAIN_HEAVY,
    DRAIN_PERIODIC
  } drain_style_e;

  logic clk;
  logic rst;

  dqm_req_if req_ch ();
  dqm_rsp_if rsp_ch ();

  int mismatches;
  int pending;
  int compared;
  int refused;
  int peak_fill;

  int ops_sent   = 0;
  int burst_left = 4;

  deque_with_middle_insert_remove #(
    .DEPTH      (Depth),
    .ENTRY_BITS (EntryBits)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dqm_scoreboard #(
    .Depth     (Depth),
    .EntryBits (EntryBits)
  ) u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared),
    .refused    (refused),
    .peak_fill  (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: pick a stall style for a stretch of cycles, then switch.
  drain_style_e drain_style = DRAIN_FREE;
  int           drain_left  = 40;
  logic [1:0]   drain_phase = '0;

  initial rsp_ch.ready = 1'b0;

  always @(posedge clk) begin
    drain_phase <= drain_phase + 2'd1;
    if (drain_left == 0) begin
      drain_style <= drain_style_e'($urandom_range(0, 3));
      drain_left  <= $urandom_range(16, 96);
    end else begin
      drain_left <= drain_left - 1;
    end
    case (drain_style)
      DRAIN_FREE:  rsp_ch.ready <= 1'b1;
      DRAIN_LIGHT: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
      DRAIN_HEAVY: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
      default:     rsp_ch.ready <= (drain_phase != 2'd3);
    endcase
  end

  // Entry words lean toward the extremes now and then.
  function automatic word_t pick_entry();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Present one operation and hold it until its transfer; idle between bursts.
  task automatic send_op(input mode_t op, input word_t word);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.mode  <= op;
    req_ch.entry <= word;
    do @(posedge clk); while (!req_ch.ready);
    ops_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int push_pct;
    int phase_len;
    int roll;
    int waited;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_PUSH_FRONT;
    req_ch.entry = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: refusals on an empty and a one-entry list, spare codes,
    // middle operations on short lists, then drain back to empty.
    send_op(MODE_POP_FRONT,  32'h1234_5678);
    send_op(MODE_POP_BACK,   32'h0);
    send_op(MODE_REM_MID,    32'hFFFF_FFFF);
    send_op(MODE_INS_MID,    32'hDEAD_BEEF);
    send_op(MODE_SPARE_A,    32'h0);
    send_op(MODE_SPARE_B,    32'hFFFF_FFFF);
    send_op(MODE_PUSH_FRONT, 32'h0000_0000);
    send_op(MODE_INS_MID,    32'h0F0F_0F0F);
    send_op(MODE_REM_MID,    32'h0);
    send_op(MODE_PUSH_BACK,  32'hFFFF_FFFF);
    send_op(MODE_INS_MID,    32'hA5A5_A5A5);
    send_op(MODE_INS_MID,    32'h5A5A_5A5A);
    send_op(MODE_PUSH_FRONT, 32'h0000_0001);
    send_op(MODE_SPARE_A,    32'hFFFF_FFFF);
    send_op(MODE_REM_MID,    32'h0);
    send_op(MODE_REM_MID,    32'h0);
    send_op(MODE_POP_FRONT,  32'h0);
    send_op(MODE_POP_BACK,   32'h0);
    send_op(MODE_POP_BACK,   32'h0);
    send_op(MODE_POP_FRONT,  32'h0);

    // Fill past the top with end pushes, then try every push on a full list.
    repeat (36) begin
      send_op($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_entry());
    end
    send_op(MODE_PUSH_FRONT, pick_entry());
    send_op(MODE_PUSH_BACK,  pick_entry());
    send_op(MODE_INS_MID,    pick_entry());

    // Drain past empty with a mix of removals.
    repeat (36) begin
      send_op(mode_t'($urandom_range(3, 5)), pick_entry());
    end

    // Random phases that lean toward growth, balance or shrinkage.
    while (ops_sent < RandomTarget) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
          send_op(mode_t'($urandom_range(0, 2)), pick_entry());
        else if (roll < 98)
          send_op(mode_t'($urandom_range(3, 5)), pick_entry());
        else
          send_op(mode_t'($urandom_range(6, 7)), pick_entry());
      end
    end
    req_ch.valid <= 1'b0;

    // Let the scoreboard count the last transfer, then wait out outstanding
    // results and let the scoreboard counters settle.
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);

    $display("Sent %0d operations; compared %0d results, %0d of them refusals.",
             ops_sent, compared, refused);
    $display("List reached a fill of %0d out of %0d entries.", peak_fill, Depth);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
